// File: sv/pets_pkg.sv
`default_nettype none

package pets_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 16;
    localparam int ENTRY_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FREE_W      = $clog2(MAX_ENTRIES + 1);
    localparam int INDEX_W     = 4;
    localparam int STAT_W      = 32;

    // Request modes
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Input request
    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] entry_index;
        logic [STAT_W-1:0]  delta;
    } req_t;

    // Result
    typedef struct packed {
        logic [INDEX_W-1:0] index_out;
        logic               table_full;
        logic [STAT_W-1:0]  average;
        logic [STAT_W-1:0]  minimum;
        logic [STAT_W-1:0]  maximum;
        logic [STAT_W-1:0]  sample_count;
    } rsp_t;

    // One stored table entry
    typedef struct packed {
        logic [STAT_W-1:0] average;
        logic [STAT_W-1:0] minimum;
        logic [STAT_W-1:0] maximum;
        logic [STAT_W-1:0] sample_count;
    } entry_t;

endpackage

`default_nettype wire

// File: sv/per_entry_timing_statistics.sv
`default_nettype none

// Per-entry timing statistics table. An add request claims the next free
// entry, clears it and returns its index (table_full is set and nothing changes
// once all MAX_ENTRIES entries are taken). An update request folds a time
// sample into the named entry: the first sample seeds average, minimum and
// maximum; later samples halve the 33-bit sum of average and sample and track
// the extremes; the count wraps to zero. Each request gives exactly one result.
// Statistics live in a single-port synchronous memory with a registered
// read: ST_IDLE accepts a request and reads its entry; ST_CALC updates it,
// writes it back and loads the result register, stalling while that register
// holds an untaken result. No new request is taken until ST_CALC ends; the
// result register lets the next request be accepted while a result waits.
// Reset clears the table at once through per-entry valid bits.
module per_entry_timing_statistics (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire pets_pkg::req_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output pets_pkg::rsp_t       m_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic                            state_reg, state_next;
    pets_pkg::req_t                  req_reg;
    logic [pets_pkg::FREE_W-1:0]     next_free_reg;
    logic [pets_pkg::MAX_ENTRIES-1:0] valid_reg;
    logic                            rd_valid_reg;
    pets_pkg::entry_t                rd_data_reg;
    pets_pkg::entry_t                mem [pets_pkg::MAX_ENTRIES];
    logic                            m_valid_reg;
    pets_pkg::rsp_t                  m_data_reg;

    logic                            s_fire;
    logic                            out_free;
    logic                            finish;
    logic [pets_pkg::ENTRY_W-1:0]    req_addr;
    logic                            idx_ok;
    logic                            table_full;
    pets_pkg::entry_t                old_entry;
    pets_pkg::entry_t                new_entry;
    logic                            first;
    logic [pets_pkg::STAT_W:0]       avg_sum;
    logic                            wr_en;
    pets_pkg::rsp_t                  rsp_next;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_CALC) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign req_addr   = req_reg.entry_index[pets_pkg::ENTRY_W-1:0];
    assign idx_ok     = ({1'b0, req_reg.entry_index} <
                         (pets_pkg::INDEX_W + 1)'(pets_pkg::MAX_ENTRIES));
    assign table_full = (next_free_reg >= pets_pkg::FREE_W'(pets_pkg::MAX_ENTRIES));

    // Sequence read then update
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Fold the sample into the entry
    always_comb begin
        old_entry = rd_valid_reg ? rd_data_reg : '0;
        first     = (old_entry.sample_count == '0);
        avg_sum   = {1'b0, old_entry.average} + {1'b0, req_reg.delta};
        new_entry.sample_count = old_entry.sample_count + 1'b1;
        if (first) begin
            new_entry.average = req_reg.delta;
            new_entry.minimum = req_reg.delta;
            new_entry.maximum = req_reg.delta;
        end else begin
            new_entry.average = avg_sum[pets_pkg::STAT_W:1];
            new_entry.minimum = (req_reg.delta < old_entry.minimum) ?
                                req_reg.delta : old_entry.minimum;
            new_entry.maximum = (req_reg.delta > old_entry.maximum) ?
                                req_reg.delta : old_entry.maximum;
        end
    end

    // Build the result
    always_comb begin
        rsp_next = '0;
        wr_en    = 1'b0;
        if (req_reg.mode == pets_pkg::MODE_ADD) begin
            if (table_full) begin
                rsp_next.table_full = 1'b1;
            end else begin
                rsp_next.index_out = pets_pkg::INDEX_W'(next_free_reg);
            end
        end else begin
            rsp_next.index_out = req_reg.entry_index;
            if (idx_ok) begin
                wr_en                 = finish;
                rsp_next.average      = new_entry.average;
                rsp_next.minimum      = new_entry.minimum;
                rsp_next.maximum      = new_entry.maximum;
                rsp_next.sample_count = new_entry.sample_count;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_free_reg <= '0;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
                if (req_reg.mode == pets_pkg::MODE_ADD) begin
                    if (!table_full) begin
                        valid_reg[next_free_reg[pets_pkg::ENTRY_W-1:0]] <= 1'b0;
                        next_free_reg <= next_free_reg + 1'b1;
                    end
                end else if (wr_en) begin
                    valid_reg[req_addr] <= 1'b1;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request and its entry's valid bit
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg      <= s_data;
            rd_valid_reg <= valid_reg[s_data.entry_index[pets_pkg::ENTRY_W-1:0]];
        end
        if (finish) begin
            m_data_reg <= rsp_next;
        end
    end

    // Statistics memory: registered read, write back
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg <= mem[s_data.entry_index[pets_pkg::ENTRY_W-1:0]];
        end
        if (wr_en) begin
            mem[req_addr] <= new_entry;
        end
    end

endmodule

`default_nettype wire
